FILE: rtl/core/dlsl_pkg.sv
// Shared types and constants for the daily light schedule lamp controller.
// No dependencies; every other file imports this package.
`default_nettype none

package dlsl_pkg;

    localparam int TIME_W     = 32;   // timestamp width, differences wrap
    localparam int LIGHT_W    = 27;   // light total and target width
    localparam int THR_W      = 10;   // dark threshold width
    localparam int INTV_W     = 16;   // sample interval width
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;

    localparam logic [LIGHT_W-1:0] MARGIN_MS       = LIGHT_W'(3600);
    localparam logic [THR_W-1:0]   RST_THRESHOLD   = THR_W'(1000);
    localparam logic [INTV_W-1:0]  RST_INTERVAL_MS = INTV_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIM_LIMIT       = 2'd0,
        CFG_SAMPLE_INTERVAL = 2'd1,
        CFG_TARGET_LIGHT    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [THR_W-1:0]   dim_limit;
        logic [INTV_W-1:0]  sample_interval_ms;
        logic [LIGHT_W-1:0] target_light_ms;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0]  day_start;
        logic [TIME_W-1:0]  last_sample;
        logic [LIGHT_W-1:0] light_accum;
        logic               lamp_state;
    } t_day_state;

    typedef struct packed {
        logic               lamp_on;
        logic [LIGHT_W-1:0] light_total_ms;
        logic               sampled;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/dlsl_in_if.sv
// Request channel carrying one timestamp and one light reading.
// Depends on dlsl_pkg for the timestamp width.
`default_nettype none

interface dlsl_in_if
    import dlsl_pkg::*;
#(
    parameter int SENSOR_BITS = 10
) ();
    logic                   valid;
    logic                   ready;
    logic [TIME_W-1:0]      now_ms;
    logic [SENSOR_BITS-1:0] light_level;

    modport source (output valid, output now_ms, output light_level, input ready);
    modport sink   (input valid, input now_ms, input light_level, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dlsl_out_if.sv
// Result channel: lamp drive, light total and sample flag.
// Depends on dlsl_pkg for the light total width.
`default_nettype none

interface dlsl_out_if
    import dlsl_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               lamp_on;
    logic [LIGHT_W-1:0] light_total_ms;
    logic               sampled;

    modport source (output valid, output lamp_on, output light_total_ms, output sampled,
                    input ready);
    modport sink   (input valid, input lamp_on, input light_total_ms, input sampled,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/core/dlsl_update.sv
// Per-request update: day rollover, sample gate, schedule compare, accumulation.
// Purely combinational; depends on dlsl_pkg types.
`default_nettype none

module dlsl_update
    import dlsl_pkg::*;
#(
    parameter int DAY_LENGTH_MS = 86400000,
    parameter int SENSOR_BITS   = 10
) (
    input  t_cfg                   i_cfg,
    input  t_day_state             i_state,
    input  logic [TIME_W-1:0]      i_now_ms,
    input  logic [SENSOR_BITS-1:0] i_light_level,
    output t_day_state             o_state,
    output t_result                o_result
);

    localparam int CMP_W  = (SENSOR_BITS > THR_W) ? SENSOR_BITS : THR_W;
    localparam int PROD_W = 2 * LIGHT_W + 1;
    localparam int SUM_W  = TIME_W + 1;
    localparam logic [LIGHT_W-1:0] DAY = LIGHT_W'(DAY_LENGTH_MS);

    logic [TIME_W-1:0]  day_diff;
    logic               rollover;
    logic [TIME_W-1:0]  day_start;
    logic [LIGHT_W-1:0] accum;
    logic [LIGHT_W-1:0] into_day;
    logic [TIME_W-1:0]  elapsed;
    logic               take_sample;
    logic [LIGHT_W-1:0] tgt;
    logic [LIGHT_W:0]   accum_margin;
    logic [PROD_W-1:0]  have;
    logic [PROD_W-1:0]  want;
    logic               dark;
    logic               lamp;
    logic [SUM_W-1:0]   sum;
    logic [LIGHT_W-1:0] accum_sat;

    always_comb begin
        day_diff  = i_now_ms - i_state.day_start;
        rollover  = (day_diff >= TIME_W'(DAY));
        day_start = rollover ? i_now_ms : i_state.day_start;
        accum     = rollover ? '0 : i_state.light_accum;
        // after a rollover the day has just begun
        into_day  = rollover ? '0 : day_diff[LIGHT_W-1:0];

        elapsed     = i_now_ms - i_state.last_sample;
        take_sample = (elapsed >= TIME_W'(i_cfg.sample_interval_ms));

        tgt          = (i_cfg.target_light_ms > DAY) ? DAY : i_cfg.target_light_ms;
        accum_margin = {1'b0, accum} + {1'b0, MARGIN_MS};
        have         = PROD_W'(accum_margin) * PROD_W'(DAY);
        want         = PROD_W'(tgt) * PROD_W'(into_day);
        dark         = (CMP_W'(i_light_level) < CMP_W'(i_cfg.dim_limit));
        lamp         = (tgt != '0) && (accum < tgt) && (have < want) && dark;

        sum       = SUM_W'(elapsed) + SUM_W'(accum);
        accum_sat = (sum > SUM_W'(DAY)) ? DAY : sum[LIGHT_W-1:0];

        o_state.day_start   = day_start;
        o_state.last_sample = take_sample ? i_now_ms : i_state.last_sample;
        o_state.lamp_state  = take_sample ? lamp : i_state.lamp_state;
        o_state.light_accum = (take_sample && (!dark || lamp)) ? accum_sat : accum;

        o_result.lamp_on        = o_state.lamp_state;
        o_result.light_total_ms = o_state.light_accum;
        o_result.sampled        = take_sample;
    end

endmodule

`default_nettype wire

FILE: rtl/core/daily_light_schedule_lamp_control_top.sv
// Top level of the daily light schedule lamp controller: request register,
// day state, config registers and result register. Uses dlsl_pkg, the two
// channel interfaces and dlsl_update.
//
//  channel   dir  handshake        payload
//  i_in      in   valid / ready    now_ms[31:0], light_level[SENSOR_BITS-1:0]
//  o_out     out  valid / ready    lamp_on, light_total_ms[26:0], sampled
//  config    in   i_cfg_we         i_cfg_idx[1:0], i_cfg_data[26:0]
//
// A request accepted into the request register moves on into the result register once
// that is empty or its result is taken; while no result stalls, one request per cycle
// is accepted. The day state is updated in the same cycle the result is registered,
// so each request sees the state left by the one before it.
// The multiply-compare in dlsl_update sets the clock period.
// Synchronous active-low reset clears state and loads config defaults.
// A stalled result keeps its register; the request register keeps filling
// until it holds a request that cannot move on.
`default_nettype none

module daily_light_schedule_lamp_control_top
    import dlsl_pkg::*;
#(
    parameter int DAY_LENGTH_MS = 86400000,
    parameter int SENSOR_BITS   = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    dlsl_in_if.sink               i_in,
    dlsl_out_if.source            o_out
);

    t_cfg                   r_cfg;
    t_day_state             r_state;
    t_day_state             n_state;
    t_result                n_res;
    t_result                r_res;
    logic                   r_in_valid;
    logic [TIME_W-1:0]      r_now;
    logic [SENSOR_BITS-1:0] r_level;
    logic                   r_out_valid;
    logic                   adv;

    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    assign o_out.valid          = r_out_valid;
    assign o_out.lamp_on        = r_res.lamp_on;
    assign o_out.light_total_ms = r_res.light_total_ms;
    assign o_out.sampled        = r_res.sampled;

    dlsl_update #(
        .DAY_LENGTH_MS (DAY_LENGTH_MS),
        .SENSOR_BITS   (SENSOR_BITS)
    ) u_update (
        .i_cfg         (r_cfg),
        .i_state       (r_state),
        .i_now_ms      (r_now),
        .i_light_level (r_level),
        .o_state       (n_state),
        .o_result      (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dim_limit          <= RST_THRESHOLD;
            r_cfg.sample_interval_ms <= RST_INTERVAL_MS;
            r_cfg.target_light_ms    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIM_LIMIT:       r_cfg.dim_limit          <= i_cfg_data[THR_W-1:0];
                CFG_SAMPLE_INTERVAL: r_cfg.sample_interval_ms <= i_cfg_data[INTV_W-1:0];
                CFG_TARGET_LIGHT:    r_cfg.target_light_ms    <= i_cfg_data[LIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_now   <= i_in.now_ms;
            r_level <= i_in.light_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_res;
        end
    end

    // total never runs past one day
    a_accum_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.light_accum <= LIGHT_W'(DAY_LENGTH_MS))
        else $error("light total above day length");

    // a sampling request leaves its timestamp as the last sample
    a_sample_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && n_res.sampled |=> r_state.last_sample == $past(r_now))
        else $error("last sample not updated");

    // a held request keeps its payload until it moves on
    a_req_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_now) && $stable(r_level))
        else $error("request register lost its request");

    // an empty result register never blocks new requests
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("ready low with empty result register");

endmodule

`default_nettype wire
